>>> hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, cond, msg)
`define ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

>>> hdl/thiele_pkg.sv
// ----------------------------------------------------------------------------
// thiele_pkg
// shared constants and types of the thiele interpolation step unit
// ----------------------------------------------------------------------------
package thiele_pkg;
    localparam int unsigned W = 63;
    localparam int unsigned MAX_POINTS_DEF = 64;
    localparam logic [W-1:0] PRIME_RESET = 63'd9223372036854775783;

    localparam logic [2:0] ST_STORED = 3'd0;
    localparam logic [2:0] ST_RECON  = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_ZERO   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    // state machine
    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_REDUCE = 14'b00000000000010,
        S_RD     = 14'b00000000000100,
        S_RDW    = 14'b00000000001000,
        S_EINV   = 14'b00000000010000,
        S_EMUL   = 14'b00000000100000,
        S_EADD   = 14'b00000001000000,
        S_CHECK  = 14'b00000010000000,
        S_CRD    = 14'b00000100000000,
        S_CRDW   = 14'b00001000000000,
        S_CINV   = 14'b00010000000000,
        S_CMUL   = 14'b00100000000000,
        S_WRITE  = 14'b01000000000000,
        S_RESULT = 14'b10000000000000
    } state_t;

    // modular multiplier control ops
    typedef enum logic [1:0] {
        M_NONE = 2'd0,
        M_MUL  = 2'd1,
        M_INV  = 2'd2
    } mop_t;
endpackage

>>> hdl/thiele_modmul.sv
// ----------------------------------------------------------------------------
// thiele_modmul
// bit-serial modular multiply and fermat inverse, one bit per cycle
// ----------------------------------------------------------------------------
module thiele_modmul (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     go,
    input  thiele_pkg::mop_t         op,
    input  logic [thiele_pkg::W-1:0] a,
    input  logic [thiele_pkg::W-1:0] b,
    input  logic [thiele_pkg::W-1:0] p,
    output logic                     done,
    output logic [thiele_pkg::W-1:0] res
);
    localparam int unsigned W = thiele_pkg::W;

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_MUL  = 4'b0010,
        U_EXP  = 4'b0100,
        U_FIN  = 4'b1000
    } ustate_t;

    ustate_t ust_reg;
    logic          inv_reg;
    logic          sq_reg;      // exp: 1 -> squaring base, 0 -> r*base
    logic [W-1:0]  ma_reg, mb_reg, acc_reg;
    logic [W-1:0]  base_reg, r_reg, e_reg;

    function automatic logic [W-1:0] madd(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
        logic [W:0] s;
        begin
            s = {1'b0, x} + {1'b0, y};
            madd = (s >= {1'b0, m}) ? W'(s - {1'b0, m}) : s[W-1:0];
        end
    endfunction

    assign res = inv_reg ? r_reg : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ust_reg <= U_IDLE;
            done <= 1'b0;
            inv_reg <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (ust_reg)
                U_IDLE:
                begin
                    if (go && op == thiele_pkg::M_MUL)
                    begin
                        ma_reg <= a; mb_reg <= b; acc_reg <= '0;
                        inv_reg <= 1'b0;
                        ust_reg <= U_MUL;
                    end
                    else if (go && op == thiele_pkg::M_INV)
                    begin
                        base_reg <= a; r_reg <= W'(1); e_reg <= p - W'(2);
                        inv_reg <= 1'b1;
                        ust_reg <= U_EXP;
                    end
                end
                U_EXP:
                begin
                    if (e_reg == '0)
                    begin
                        ust_reg <= U_FIN;
                    end
                    else if (e_reg[0])
                    begin
                        ma_reg <= r_reg; mb_reg <= base_reg; acc_reg <= '0;
                        sq_reg <= 1'b0;
                        ust_reg <= U_MUL;
                    end
                    else
                    begin
                        ma_reg <= base_reg; mb_reg <= base_reg; acc_reg <= '0;
                        sq_reg <= 1'b1;
                        ust_reg <= U_MUL;
                    end
                end
                U_MUL:
                begin
                    if (mb_reg == '0)
                    begin
                        if (!inv_reg)
                            ust_reg <= U_FIN;
                        else
                        begin
                            if (sq_reg)
                            begin
                                base_reg <= acc_reg;
                                e_reg <= e_reg >> 1;
                            end
                            else
                            begin
                                r_reg <= acc_reg;
                                e_reg <= {e_reg[W-1:1], 1'b0};
                            end
                            ust_reg <= U_EXP;
                        end
                    end
                    else
                    begin
                        if (mb_reg[0])
                            acc_reg <= madd(acc_reg, ma_reg, p);
                        ma_reg <= madd(ma_reg, ma_reg, p);
                        mb_reg <= mb_reg >> 1;
                    end
                end
                U_FIN:
                begin
                    done <= 1'b1;
                    ust_reg <= U_IDLE;
                end
                default: ust_reg <= U_IDLE;
            endcase
        end
    end
endmodule

>>> hdl/thiele_interpolation_step_unit.sv
// ----------------------------------------------------------------------------
// thiele_interpolation_step_unit
// incremental thiele continued-fraction interpolation modulo a prime
// ----------------------------------------------------------------------------
// channel   | signals                                          | handshake
// request   | sample_point function_value begin_new            | start & !busy
// result    | status coefficient coefficient_count             | done strobe
// config    | cfg_we cfg_data                                  | cfg_we
// one request at a time; busy stays high until the result strobe
// cost: n stored entries take 2n-1 inverses (square and multiply over up to 63 exponent
// bits) and 2n-1 multiplies, all on the one bit-serial mod unit
// the request pair and every stored read are reduced by shift-subtract
// reset clears count and flag; stores are undefined until written; results cannot stall
module thiele_interpolation_step_unit #(
    parameter int unsigned MAX_POINTS = thiele_pkg::MAX_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [thiele_pkg::W-1:0]      sample_point,
    input  logic [thiele_pkg::W-1:0]      function_value,
    input  logic                          begin_new,
    input  logic                          cfg_we,
    input  logic [thiele_pkg::W-1:0]      cfg_data,
    output logic                          done,
    output logic [2:0]                    status,
    output logic [thiele_pkg::W-1:0]      coefficient,
    output logic [$clog2(MAX_POINTS+1)-1:0] coefficient_count
);
    localparam int unsigned W  = thiele_pkg::W;
    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned CW = $clog2(MAX_POINTS+1);

    thiele_pkg::state_t st_reg;
    logic [W-1:0]  prime_reg, p_reg;
    logic [W-1:0]  y_reg, v_reg, r_reg;
    logic [W:0]    ry_reg, rv_reg;      // shift-subtract remainders
    logic [W-1:0]  dy_reg;              // shifted divisor
    logic [6:0]    rsh_reg;
    logic          rdred_reg;           // reducing stored values, not the request
    logic          cpass_reg;           // coefficient pass
    logic [CW-1:0] cnt_reg, n_reg;
    logic [CW-1:0] k_reg;
    logic          flag_reg;
    logic [W-1:0]  t_rd, a_rd;
    logic [W-1:0]  tr_reg, ar_reg;
    logic          mbusy_reg;
    logic [W-1:0]  pt_mem [MAX_POINTS];
    logic [W-1:0]  cf_mem [MAX_POINTS];
    logic [W-1:0]  ms_y;

    logic                 mu_go, mu_done;
    thiele_pkg::mop_t     mu_op;
    logic [W-1:0]         mu_a, mu_b, mu_res;
    logic                 wr_en;
    logic [AW-1:0]        rd_addr;

    thiele_modmul u_mul (
        .clk(clk), .rst_n(rst_n), .go(mu_go), .op(mu_op),
        .a(mu_a), .b(mu_b), .p(p_reg), .done(mu_done), .res(mu_res)
    );

    function automatic logic [W-1:0] msub(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
        begin
            msub = (x >= y) ? x - y : x + (m - y);
        end
    endfunction

    function automatic logic [W-1:0] madd(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
        logic [W:0] s;
        begin
            s = {1'b0, x} + {1'b0, y};
            madd = (s >= {1'b0, m}) ? W'(s - {1'b0, m}) : s[W-1:0];
        end
    endfunction

    // memories: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pt_mem[n_reg[AW-1:0]] <= y_reg;
            cf_mem[n_reg[AW-1:0]] <= r_reg;
        end
        t_rd <= pt_mem[rd_addr];
        a_rd <= cf_mem[rd_addr];
    end

    assign wr_en = (st_reg == thiele_pkg::S_WRITE);
    assign rd_addr = k_reg[AW-1:0];
    assign busy = (st_reg != thiele_pkg::S_IDLE);
    assign ms_y = msub(y_reg, tr_reg, p_reg);
    assign mu_a = r_reg;
    assign mu_b = ms_y;

    // one launch per operation, held off while the mod unit runs
    always_comb
    begin
        mu_go = 1'b0;
        mu_op = thiele_pkg::M_NONE;
        case (st_reg)
            thiele_pkg::S_EINV, thiele_pkg::S_CINV:
            begin
                mu_op = thiele_pkg::M_INV;
                mu_go = !mbusy_reg && (r_reg != '0);
            end
            thiele_pkg::S_EMUL, thiele_pkg::S_CMUL:
            begin
                mu_op = thiele_pkg::M_MUL;
                mu_go = !mbusy_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= thiele_pkg::S_IDLE;
            prime_reg <= thiele_pkg::PRIME_RESET;
            cnt_reg <= '0;
            flag_reg <= 1'b0;
            done <= 1'b0;
            mbusy_reg <= 1'b0;
            rdred_reg <= 1'b0;
            cpass_reg <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (cfg_we)
                prime_reg <= cfg_data;
            case (st_reg)
                thiele_pkg::S_IDLE:
                begin
                    if (start)
                    begin
                        p_reg <= (prime_reg < W'(3)) ? W'(3) : prime_reg;
                        ry_reg <= {1'b0, sample_point};
                        rv_reg <= {1'b0, function_value};
                        rsh_reg <= 7'd0;
                        rdred_reg <= 1'b0;
                        cpass_reg <= 1'b0;
                        if (begin_new)
                        begin
                            cnt_reg <= '0;
                            flag_reg <= 1'b0;
                        end
                        st_reg <= thiele_pkg::S_REDUCE;
                    end
                end
                thiele_pkg::S_REDUCE:
                begin
                    // shift the divisor up while its double fits under the larger value, then subtract below p
                    if (rsh_reg == 7'd0)
                    begin
                        dy_reg <= p_reg;
                        rsh_reg <= 7'd1;
                    end
                    else if (rsh_reg[6] == 1'b0 && dy_reg[W-1] == 1'b0
                             && ({1'b0, dy_reg, 1'b0} <= {1'b0, ry_reg}
                                 || {1'b0, dy_reg, 1'b0} <= {1'b0, rv_reg}))
                    begin
                        dy_reg <= {dy_reg[W-2:0], 1'b0};
                        rsh_reg <= rsh_reg + 7'd1;
                    end
                    else if (ry_reg >= {1'b0, p_reg} || rv_reg >= {1'b0, p_reg})
                    begin
                        if (ry_reg >= {1'b0, dy_reg})
                            ry_reg <= ry_reg - {1'b0, dy_reg};
                        if (rv_reg >= {1'b0, dy_reg})
                            rv_reg <= rv_reg - {1'b0, dy_reg};
                        if (dy_reg != p_reg)
                            dy_reg <= dy_reg >> 1;
                        rsh_reg <= 7'd64;
                    end
                    else if (!rdred_reg)
                    begin
                        y_reg <= ry_reg[W-1:0];
                        v_reg <= rv_reg[W-1:0];
                        n_reg <= cnt_reg;
                        if (flag_reg)
                        begin
                            status <= thiele_pkg::ST_DONE;
                            coefficient <= '0;
                            st_reg <= thiele_pkg::S_RESULT;
                        end
                        else if (cnt_reg == '0)
                        begin
                            r_reg <= rv_reg[W-1:0];
                            st_reg <= thiele_pkg::S_WRITE;
                        end
                        else
                        begin
                            k_reg <= cnt_reg - CW'(1);
                            st_reg <= thiele_pkg::S_RD;
                        end
                    end
                    else if (!cpass_reg)
                    begin
                        tr_reg <= ry_reg[W-1:0];
                        ar_reg <= rv_reg[W-1:0];
                        if (k_reg == n_reg - CW'(1))
                        begin
                            // innermost term starts the evaluation
                            r_reg <= rv_reg[W-1:0];
                            if (k_reg == '0)
                                st_reg <= thiele_pkg::S_CHECK;
                            else
                            begin
                                k_reg <= k_reg - CW'(1);
                                st_reg <= thiele_pkg::S_RD;
                            end
                        end
                        else
                            st_reg <= thiele_pkg::S_EINV;
                    end
                    else
                    begin
                        tr_reg <= ry_reg[W-1:0];
                        r_reg <= msub(r_reg, rv_reg[W-1:0], p_reg);
                        st_reg <= thiele_pkg::S_CINV;
                    end
                end
                thiele_pkg::S_RD: st_reg <= thiele_pkg::S_RDW;
                thiele_pkg::S_RDW, thiele_pkg::S_CRDW:
                begin
                    // stored values are reduced by the current modulus on every read
                    ry_reg <= {1'b0, t_rd};
                    rv_reg <= {1'b0, a_rd};
                    rsh_reg <= 7'd0;
                    rdred_reg <= 1'b1;
                    st_reg <= thiele_pkg::S_REDUCE;
                end
                thiele_pkg::S_EINV:
                begin
                    if (!mbusy_reg)
                    begin
                        if (r_reg == '0)
                        begin
                            status <= thiele_pkg::ST_ZERO;
                            coefficient <= '0;
                            st_reg <= thiele_pkg::S_RESULT;
                        end
                        else
                            mbusy_reg <= 1'b1;
                    end
                    else if (mu_done)
                    begin
                        r_reg <= mu_res;
                        mbusy_reg <= 1'b0;
                        st_reg <= thiele_pkg::S_EMUL;
                    end
                end
                thiele_pkg::S_EMUL:
                begin
                    if (!mbusy_reg)
                        mbusy_reg <= 1'b1;
                    else if (mu_done)
                    begin
                        r_reg <= mu_res;
                        mbusy_reg <= 1'b0;
                        st_reg <= thiele_pkg::S_EADD;
                    end
                end
                thiele_pkg::S_EADD:
                begin
                    r_reg <= madd(r_reg, ar_reg, p_reg);
                    if (k_reg == '0)
                        st_reg <= thiele_pkg::S_CHECK;
                    else
                    begin
                        k_reg <= k_reg - CW'(1);
                        st_reg <= thiele_pkg::S_RD;
                    end
                end
                thiele_pkg::S_CHECK:
                begin
                    if (r_reg == v_reg)
                    begin
                        status <= thiele_pkg::ST_RECON;
                        coefficient <= '0;
                        flag_reg <= 1'b1;
                        st_reg <= thiele_pkg::S_RESULT;
                    end
                    else if (n_reg >= CW'(MAX_POINTS))
                    begin
                        status <= thiele_pkg::ST_FULL;
                        coefficient <= '0;
                        st_reg <= thiele_pkg::S_RESULT;
                    end
                    else
                    begin
                        r_reg <= v_reg;
                        k_reg <= '0;
                        cpass_reg <= 1'b1;
                        st_reg <= thiele_pkg::S_CRD;
                    end
                end
                thiele_pkg::S_CRD: st_reg <= thiele_pkg::S_CRDW;
                thiele_pkg::S_CINV:
                begin
                    if (!mbusy_reg)
                    begin
                        if (r_reg == '0)
                        begin
                            status <= thiele_pkg::ST_ZERO;
                            coefficient <= '0;
                            st_reg <= thiele_pkg::S_RESULT;
                        end
                        else
                            mbusy_reg <= 1'b1;
                    end
                    else if (mu_done)
                    begin
                        r_reg <= mu_res;
                        mbusy_reg <= 1'b0;
                        st_reg <= thiele_pkg::S_CMUL;
                    end
                end
                thiele_pkg::S_CMUL:
                begin
                    if (!mbusy_reg)
                        mbusy_reg <= 1'b1;
                    else if (mu_done)
                    begin
                        r_reg <= mu_res;
                        mbusy_reg <= 1'b0;
                        if (k_reg == n_reg - CW'(1))
                            st_reg <= thiele_pkg::S_WRITE;
                        else
                        begin
                            k_reg <= k_reg + CW'(1);
                            st_reg <= thiele_pkg::S_CRD;
                        end
                    end
                end
                thiele_pkg::S_WRITE:
                begin
                    cnt_reg <= n_reg + CW'(1);
                    status <= thiele_pkg::ST_STORED;
                    coefficient <= r_reg;
                    st_reg <= thiele_pkg::S_RESULT;
                end
                thiele_pkg::S_RESULT:
                begin
                    done <= 1'b1;
                    st_reg <= thiele_pkg::S_IDLE;
                end
                default: st_reg <= thiele_pkg::S_IDLE;
            endcase
        end
    end

    assign coefficient_count = cnt_reg;

`include "assert_macros.svh"
    `ASSERT_NEXT(a_done_one, done, !done, "result strobe longer than one cycle")
    `ASSERT_IMPL(a_cnt_range, cnt_reg <= CW'(MAX_POINTS), "count beyond store depth")
    `ASSERT_IMPL(a_done_idle, !done || !busy, "result strobe while busy")
    `ASSERT_IMPL(a_p_min, busy == 1'b0 || p_reg >= W'(3), "working modulus below three")
endmodule

>>> tb/sv/thiele_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thiele_checker
// watches the request, result and config channels of the thiele unit, predicts
// each result from its own copy of the point/coefficient stores and compares
// ----------------------------------------------------------------------------
module thiele_checker #(
    parameter int unsigned MAX_POINTS = thiele_pkg::MAX_POINTS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [thiele_pkg::W-1:0] sample_point,
    input  logic [thiele_pkg::W-1:0] function_value,
    input  logic                     begin_new,
    input  logic                     cfg_we,
    input  logic [thiele_pkg::W-1:0] cfg_data,
    input  logic                     done,
    input  logic [2:0]               status,
    input  logic [thiele_pkg::W-1:0] coefficient,
    input  logic [6:0]               coefficient_count,
    output int                       errors,
    output int                       pending
);
    localparam int unsigned W = thiele_pkg::W;

    typedef struct packed {
        logic [2:0]   st;
        logic [W-1:0] coef;
        logic [6:0]   cnt;
    } step_result_t;

    logic [W-1:0] modulus;
    logic [W-1:0] point_mem [MAX_POINTS];
    logic [W-1:0] coef_mem [MAX_POINTS];
    int unsigned  held;
    bit           recon;
    step_result_t expected_q[$];

    function automatic logic [W-1:0] mul_mod(input logic [W-1:0] a, b, p);
        logic [125:0] prod;
        prod = 126'(a % p) * 126'(b % p);
        return W'(prod % 126'(p));
    endfunction

    function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, b, p);
        logic [63:0] s;
        s = 64'(a) + 64'(b);
        return (s >= 64'(p)) ? W'(s - 64'(p)) : W'(s);
    endfunction

    function automatic logic [W-1:0] sub_mod(input logic [W-1:0] a, b, p);
        return (a >= b) ? a - b : W'(64'(a) + 64'(p - b));
    endfunction

    // inverse as x^(p-2), also for a composite modulus
    function automatic logic [W-1:0] inv_mod(input logic [W-1:0] a, p);
        logic [W-1:0] r;
        logic [W-1:0] base;
        logic [W-1:0] e;
        r = 1 % p;
        base = a % p;
        e = p - 2;
        for (int i = 0; i < W; i++)
        begin
            if (e[i])
                r = mul_mod(r, base, p);
            base = mul_mod(base, base, p);
        end
        return r;
    endfunction

    function automatic step_result_t thiele_step(input logic [W-1:0] y_raw, v_raw,
                                                 input logic bn);
        step_result_t res;
        logic [W-1:0] p;
        logic [W-1:0] y;
        logic [W-1:0] v;
        logic [W-1:0] r;
        logic [W-1:0] num;
        logic [W-1:0] den;
        bit           zero;
        int           n;
        p = (modulus < 3) ? W'(3) : modulus;
        y = y_raw % p;
        v = v_raw % p;
        res = '0;
        zero = 0;
        if (bn)
        begin
            held = 0;
            recon = 0;
        end
        if (recon)
            res.st = thiele_pkg::ST_DONE;
        else if (held == 0)
        begin
            point_mem[0] = y;
            coef_mem[0] = v;
            held = 1;
            res.st = thiele_pkg::ST_STORED;
            res.coef = v;
        end
        else
        begin
            n = held;
            // evaluate the fraction from the innermost term out
            r = coef_mem[n-1] % p;
            for (int k = n - 1; k > 0 && !zero; k--)
            begin
                if (r == 0)
                    zero = 1;
                else
                begin
                    num = sub_mod(y, point_mem[k-1] % p, p);
                    r = add_mod(coef_mem[k-1] % p, mul_mod(num, inv_mod(r, p), p), p);
                end
            end
            if (zero)
                res.st = thiele_pkg::ST_ZERO;
            else if (r == v)
            begin
                res.st = thiele_pkg::ST_RECON;
                recon = 1;
            end
            else if (n >= MAX_POINTS)
                res.st = thiele_pkg::ST_FULL;
            else
            begin
                r = v;
                for (int k = 0; k < n && !zero; k++)
                begin
                    den = sub_mod(r, coef_mem[k] % p, p);
                    if (den == 0)
                        zero = 1;
                    else
                    begin
                        num = sub_mod(y, point_mem[k] % p, p);
                        r = mul_mod(num, inv_mod(den, p), p);
                    end
                end
                if (zero)
                    res.st = thiele_pkg::ST_ZERO;
                else
                begin
                    point_mem[n] = y;
                    coef_mem[n] = r;
                    held = n + 1;
                    res.st = thiele_pkg::ST_STORED;
                    res.coef = r;
                end
            end
        end
        res.cnt = 7'(held);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        step_result_t want;
        if (!rst_n)
        begin
            modulus = thiele_pkg::PRIME_RESET;
            held = 0;
            recon = 0;
            expected_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with no request waiting: got status %0d coef %0d count %0d",
                             $time, status, coefficient, coefficient_count);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (status !== want.st)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                        errors++;
                    end
                    if (coefficient !== want.coef)
                    begin
                        $display("%0t: coefficient expected %0d actual %0d",
                                 $time, want.coef, coefficient);
                        errors++;
                    end
                    if (coefficient_count !== want.cnt)
                    begin
                        $display("%0t: coefficient_count expected %0d actual %0d",
                                 $time, want.cnt, coefficient_count);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(thiele_step(sample_point, function_value, begin_new));
            if (cfg_we)
                modulus = cfg_data;
            pending = expected_q.size();
        end
    end
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives requests and modulus writes into the thiele unit: directed corner
// cases, then random well-formed linear sequences mixed with raw noise
// ----------------------------------------------------------------------------
module tb;
    localparam int unsigned W = thiele_pkg::W;
    localparam int WATCHDOG_LIMIT = 6000000;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    logic [W-1:0] sample_point;
    logic [W-1:0] function_value;
    logic         begin_new;
    logic         cfg_we;
    logic [W-1:0] cfg_data;
    logic         done;
    logic [2:0]   status;
    logic [W-1:0] coefficient;
    logic [6:0]   coefficient_count;
    int           errors;
    int           pending;
    int           idle_cycles = 0;
    int           burst_left;
    int           sent;
    logic [W-1:0] cur_p;

    thiele_interpolation_step_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_point(sample_point), .function_value(function_value),
        .begin_new(begin_new), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .done(done), .status(status), .coefficient(coefficient),
        .coefficient_count(coefficient_count)
    );

    thiele_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_point(sample_point), .function_value(function_value),
        .begin_new(begin_new), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .done(done), .status(status), .coefficient(coefficient),
        .coefficient_count(coefficient_count), .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [W-1:0] rand63();
        return W'({$urandom, $urandom});
    endfunction

    task automatic send_request(input logic [W-1:0] y, v, input logic bn);
        bit ok;
        if (burst_left <= 0)
        begin
            start <= 0;
            if ($urandom_range(0, 15) == 0)
                repeat ($urandom_range(1, 20000)) @(posedge clk);
            else
                repeat ($urandom_range(1, 40)) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        start <= 1;
        sample_point <= y;
        function_value <= v;
        begin_new <= bn;
        ok = 0;
        while (!ok)
        begin
            @(negedge clk);
            ok = !busy;
            @(posedge clk);
        end
        burst_left--;
        sent++;
    endtask

    // hold off until every request has its result
    task automatic drain();
        start <= 0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_modulus(input logic [W-1:0] val);
        drain();
        cfg_we <= 1;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
        cur_p = (val < 3) ? W'(3) : val;
    endtask

    // values of a + b*y mod p over random points
    task automatic linear_sequence(input int len);
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] y;
        logic [125:0] prod;
        a = rand63() % cur_p;
        b = rand63() % cur_p;
        for (int i = 0; i < len; i++)
        begin
            y = rand63() % cur_p;
            prod = 126'(b) * 126'(y) + 126'(a);
            send_request(y, W'(prod % 126'(cur_p)), i == 0);
        end
    endtask

    initial
    begin
        rst_n = 0;
        start = 0;
        sample_point = '0;
        function_value = '0;
        begin_new = 0;
        cfg_we = 0;
        cfg_data = '0;
        burst_left = 0;
        sent = 0;
        cur_p = thiele_pkg::PRIME_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // first item on an empty store, extremes of the fields
        send_request('0, '0, 1'b1);
        send_request('1, '1, 1'b0);
        // zero divisor while forming the coefficient
        send_request(W'(5), W'(7), 1'b1);
        send_request(W'(6), W'(8), 1'b0);
        send_request(W'(9), W'(7), 1'b0);
        // zero coefficient stored, then zero divisor while evaluating
        send_request(W'(1), W'(10), 1'b1);
        send_request(W'(1), W'(11), 1'b0);
        send_request(W'(4), W'(12), 1'b0);
        // constant function reconstructs, later items are ignored
        send_request(W'(3), W'(5), 1'b1);
        send_request(W'(8), W'(5), 1'b0);
        send_request(W'(9), W'(9), 1'b0);
        send_request('1, '0, 1'b0);
        // modulus change with points still stored
        send_request(W'(100), W'(200), 1'b1);
        send_request(W'(300), W'(400), 1'b0);
        write_modulus(W'(157));
        send_request(W'(500), '1, 1'b0);
        // small register value acts as three
        write_modulus('0);
        send_request(W'(1), W'(2), 1'b1);
        send_request(W'(2), W'(0), 1'b0);
        send_request(W'(5), W'(4), 1'b0);
        write_modulus('1);
        send_request('1, W'(6), 1'b1);
        send_request(W'(12345), '1, 1'b0);
        write_modulus(W'(3));
        send_request(W'(7), W'(8), 1'b1);
        send_request(W'(2), W'(2), 1'b0);

        write_modulus(thiele_pkg::PRIME_RESET);
        while (sent < 100)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: write_modulus(thiele_pkg::PRIME_RESET);
                    1: write_modulus(W'($urandom_range(0, 40)));
                    2: write_modulus(W'(1000003));
                    3: write_modulus('1);
                    default: write_modulus(rand63());
                endcase
            end
            case ($urandom_range(0, 9))
                7, 8:
                begin
                    send_request(rand63(), rand63(), 1'b1);
                    repeat ($urandom_range(1, 3))
                        send_request(rand63(), rand63(), $urandom_range(0, 7) == 0);
                end
                9:
                begin
                    drain();
                    linear_sequence($urandom_range(2, 4));
                end
                default:
                begin
                    linear_sequence($urandom_range(2, 4));
                    repeat ($urandom_range(0, 2))
                        send_request(rand63(), rand63(), 1'b0);
                end
            endcase
        end

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> sim.f
+incdir+hdl
hdl/thiele_pkg.sv
hdl/thiele_modmul.sv
hdl/thiele_interpolation_step_unit.sv
tb/sv/thiele_checker.sv
tb/sv/tb.sv
